// File: rtl/core/mmfn_pkg.sv
package mmfn_pkg;

  localparam int MAX_PIXELS_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W    = 16;
  localparam int PCOUNT_W    = 17;
  localparam int RANGE_W     = 16;
  localparam int NORM_W      = 24;
  localparam int SCALE_W     = 40;
  localparam int SCALE_SPLIT = 20;
  localparam int FRAC_SHIFT  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 17'd65536;
  localparam logic [RANGE_W-1:0]  RANGE_RESET  = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_COUNT  = 2'd0,
    REG_TARGET_RANGE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic last;
    logic flat;
  } tag_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/mmfn_store.sv
module mmfn_store #(
  parameter int DEPTH  = mmfn_pkg::MAX_PIXELS_DEF,
  parameter int DATA_W = mmfn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);
  import mmfn_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Read-first: the old pixel at this position comes out while the new one goes in.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// File: rtl/core/mmfn_div.sv
module mmfn_div #(
  parameter int SAMPLE_BITS = mmfn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mmfn_pkg::SCALE_W-1:0] dividend,
  input  logic [SAMPLE_BITS-1:0]       divisor,
  output mmfn_pkg::div_stat_t          stat,
  output logic [mmfn_pkg::SCALE_W-1:0] quotient
);
  import mmfn_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(SCALE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALE_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SCALE_W-1:0] num;
  logic [SW-1:0]    rem;
  logic [SW-1:0]    divisor_r;

  logic [SW:0] rem_sh;
  logic [SW:0] rem_next;
  logic        fits;

  always_comb begin
    rem_sh   = {rem, num[SCALE_W-1]};
    fits     = rem_sh >= {1'b0, divisor_r};
    rem_next = fits ? (rem_sh - {1'b0, divisor_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      rem       <= '0;
      divisor_r <= divisor;
    end else if (busy) begin
      num <= {num[SCALE_W-2:0], fits};
      rem <= rem_next[SW-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = num;

endmodule

// File: rtl/core/mmfn_scale.sv
module mmfn_scale #(
  parameter int SAMPLE_BITS = mmfn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         item_valid,
  input  mmfn_pkg::tag_t               item_tag,
  input  logic [SAMPLE_BITS-1:0]       rdata,
  input  logic [SAMPLE_BITS-1:0]       held_min,
  input  logic [SAMPLE_BITS-1:0]       held_span,
  input  logic [mmfn_pkg::SCALE_W-1:0] scale,
  output logic                         busy,
  output logic                         out_valid,
  output logic [mmfn_pkg::NORM_W-1:0]  norm_value,
  output logic                         frame_last,
  output logic                         flat_frame
);
  import mmfn_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int LO_W  = SW + SCALE_SPLIT;
  localparam int HI_W  = SW + SCALE_W - SCALE_SPLIT;
  localparam int SUM_W = SW + SCALE_W;
  localparam int SH_W  = SUM_W - FRAC_SHIFT;

  logic v1, v2, v3, v4;
  tag_t tag1, tag2, tag3, tag4;
  logic [SW-1:0]   off2, off3;
  logic [LO_W-1:0] plo3, plo4;
  logic [HI_W-1:0] phi4;

  logic [SW-1:0]     diff;
  logic [SW-1:0]     off_next;
  logic [SUM_W-1:0]  sum;
  logic [SH_W-1:0]   shifted;
  logic              sat;
  logic [NORM_W-1:0] norm_next;

  always_comb begin
    diff = rdata - held_min;
    if (rdata < held_min) begin
      off_next = '0;
    end else if (diff > held_span) begin
      off_next = held_span;
    end else begin
      off_next = diff;
    end
    sum       = (SUM_W'(phi4) << SCALE_SPLIT) + SUM_W'(plo4);
    shifted   = sum[SUM_W-1:FRAC_SHIFT];
    sat       = |shifted[SH_W-1:NORM_W];
    if (tag4.flat) begin
      norm_next = '0;
    end else if (sat) begin
      norm_next = '1;
    end else begin
      norm_next = shifted[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= item_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1       <= item_tag;
      tag2       <= tag1;
      off2       <= off_next;
      tag3       <= tag2;
      off3       <= off2;
      plo3       <= off2 * scale[SCALE_SPLIT-1:0];
      tag4       <= tag3;
      plo4       <= plo3;
      phi4       <= off3 * scale[SCALE_W-1:SCALE_SPLIT];
      norm_value <= norm_next;
      frame_last <= tag4.last;
      flat_frame <= tag4.flat;
    end
  end

  assign busy = v1 | v2 | v3 | v4;

endmodule

// File: rtl/core/min_max_frame_normalizer.sv
// Each accepted pixel passes the store read, offset, partial product, product and output
// registers; its result is for the pixel stored at that position one frame earlier.
// One pixel per cycle inside a frame while the output does not stall. After the last pixel
// input holds off for the 40-step divider and pipeline drain, or the drain alone if flat.
// Reset is synchronous and clears control state; the frame store is not cleared, and
// the first frame after reset produces no results.
module min_max_frame_normalizer #(
  parameter int MAX_PIXELS  = mmfn_pkg::MAX_PIXELS_DEF,
  parameter int SAMPLE_BITS = mmfn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmfn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmfn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mmfn_pkg::SAMPLE_W-1:0]   sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mmfn_pkg::NORM_W-1:0]     norm_value,
  output logic                            frame_last,
  output logic                            flat_frame
);
  import mmfn_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int IDX_W = $clog2(MAX_PIXELS);
  localparam int LEN_W = ($clog2(MAX_PIXELS + 1) > PCOUNT_W) ? $clog2(MAX_PIXELS + 1) : PCOUNT_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PIXELS);

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_DIV    = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;

  logic [PCOUNT_W-1:0] pixel_count;
  logic [RANGE_W-1:0]  target_range;
  logic [IDX_W-1:0]    pixel_index;
  logic [SW-1:0]       run_min, run_max;
  logic [SW-1:0]       pend_min, pend_span;
  logic [SW-1:0]       held_min, held_span;
  logic [SCALE_W-1:0]  scale;
  logic                held_flat;
  logic                primed;

  logic [SW-1:0]      s;
  logic [LEN_W-1:0]   pc_ext, frame_len, index_inc;
  logic               is_last;
  logic [SW-1:0]      min_next, max_next, span_next;
  logic               adv, accept;
  logic               pipe_busy;
  logic [SW-1:0]      store_rdata;
  tag_t               item_tag;
  div_stat_t          div_stat;
  logic [SCALE_W-1:0] quotient;

  always_comb begin
    s      = SW'(sample);
    pc_ext = LEN_W'(pixel_count);
    if (pc_ext == '0) begin
      frame_len = LEN_W'(1);
    end else if (pc_ext > LEN_MAX) begin
      frame_len = LEN_MAX;
    end else begin
      frame_len = pc_ext;
    end
    index_inc = LEN_W'(pixel_index) + LEN_W'(1);
    is_last   = index_inc >= frame_len;
    min_next  = (s < run_min) ? s : run_min;
    max_next  = (s > run_max) ? s : run_max;
    span_next = (max_next >= min_next) ? (max_next - min_next) : '0;
  end

  assign adv       = !out_valid || out_ready;
  assign in_ready  = (state == ST_RUN) && adv;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign item_tag  = '{last: is_last, flat: held_flat};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      pixel_count  <= PCOUNT_RESET;
      target_range <= RANGE_RESET;
      pixel_index  <= '0;
      run_min      <= '1;
      run_max      <= '0;
      pend_min     <= '0;
      pend_span    <= '0;
      held_min     <= '0;
      held_span    <= '0;
      scale        <= '0;
      held_flat    <= 1'b0;
      primed       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PIXEL_COUNT) begin
          pixel_count <= cfg_data;
        end else if (cfg_index == REG_TARGET_RANGE) begin
          target_range <= cfg_data[RANGE_W-1:0];
        end
      end
      unique case (state)
        ST_RUN: begin
          if (accept) begin
            if (is_last) begin
              pixel_index <= '0;
              run_min     <= '1;
              run_max     <= '0;
              pend_min    <= min_next;
              pend_span   <= span_next;
              state       <= (span_next == '0) ? ST_COMMIT : ST_DIV;
            end else begin
              pixel_index <= pixel_index + IDX_W'(1);
              run_min     <= min_next;
              run_max     <= max_next;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (!pipe_busy) begin
            held_min  <= pend_min;
            held_span <= pend_span;
            held_flat <= (pend_span == '0);
            scale     <= (pend_span == '0) ? '0 : quotient;
            primed    <= 1'b1;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  mmfn_store #(
    .DEPTH  (MAX_PIXELS),
    .DATA_W (SW)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (pixel_index),
    .wdata (s),
    .rdata (store_rdata)
  );

  mmfn_div #(
    .SAMPLE_BITS (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && is_last && (span_next != '0)),
    .dividend ({target_range, {(SCALE_W - RANGE_W){1'b0}}}),
    .divisor  (span_next),
    .stat     (div_stat),
    .quotient (quotient)
  );

  mmfn_scale #(
    .SAMPLE_BITS (SW)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (accept && primed),
    .item_tag   (item_tag),
    .rdata      (store_rdata),
    .held_min   (held_min),
    .held_span  (held_span),
    .scale      (scale),
    .busy       (pipe_busy),
    .out_valid  (out_valid),
    .norm_value (norm_value),
    .frame_last (frame_last),
    .flat_frame (flat_frame)
  );

`ifndef NO_ASSERTIONS
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> !in_ready)
    else $error("input taken right after the last pixel of a frame");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && !pipe_busy) |=> (state == ST_RUN && primed))
    else $error("frame parameters not committed once the pipeline drained");

  a_no_result_unprimed: assert property (@(posedge clk) disable iff (rst)
    !primed |-> (!out_valid && !pipe_busy))
    else $error("result produced before the first frame was stored");
`endif

endmodule
